// ===== rtl/dcos_pkg.sv =====
package dcos_pkg;

  localparam int MAX_TASKS_DEF = 64;
  localparam int MODE_W        = 2;
  localparam int TASK_W        = 7;
  localparam int PAIR_W        = 11;
  localparam int STR_W         = 17;
  localparam int QW            = STR_W;
  localparam int SW            = $clog2(QW);

  localparam logic [TASK_W-1:0] TASK_COUNT_RST = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_COMP  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_OK   = 2'd1,
    RES_BAD  = 2'd2,
    RES_COMP = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     edge_rd;
    logic     edge_wr;
    logic     clear;
    logic     comp_start;
    logic     row_rd;
    logic     row_ld;
    logic     scan;
    logic     row_wr;
    logic     den;
    logic     div_step;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic scan_last;
    logic row_last;
    logic div_last;
  } stat_t;

endpackage

// ===== rtl/dcos_ram.sv =====
module dcos_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/dcos_ctrl.sv =====
module dcos_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dcos_pkg::MODE_W-1:0]  in_mode,
  input  dcos_pkg::stat_t              stat,
  output dcos_pkg::cmd_t               cmd,
  output logic                         busy,
  output logic                         out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_WR,
    S_ROW_RD,
    S_ROW_LD,
    S_SCAN,
    S_ROW_WR,
    S_DEN,
    S_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;

  assign acc = start & ~busy_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (in_mode)
            dcos_pkg::MODE_ADD: begin
              if (stat.edge_ok) begin
                cmd.edge_rd = 1'b1;
                state_nxt   = S_EDGE_WR;
              end else begin
                cmd.res_sel   = dcos_pkg::RES_BAD;
                out_valid_nxt = 1'b1;
              end
            end
            dcos_pkg::MODE_COMP: begin
              cmd.comp_start = 1'b1;
              state_nxt      = S_ROW_RD;
            end
            dcos_pkg::MODE_CLEAR: begin
              cmd.clear     = 1'b1;
              cmd.res_sel   = dcos_pkg::RES_OK;
              out_valid_nxt = 1'b1;
            end
            default: begin
              cmd.res_sel   = dcos_pkg::RES_OK;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_EDGE_WR: begin
        cmd.edge_wr   = 1'b1;
        cmd.res_sel   = dcos_pkg::RES_OK;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_ROW_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd.row_ld = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_ROW_WR;
        end
      end
      S_ROW_WR: begin
        cmd.row_wr = 1'b1;
        state_nxt  = stat.row_last ? S_DEN : S_ROW_RD;
      end
      S_DEN: begin
        cmd.den   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          cmd.res_sel   = dcos_pkg::RES_COMP;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_edge_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDGE_WR) |=> (out_valid && !busy))
    else $error("edge write not followed by result beat");

  a_clear_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_mode == dcos_pkg::MODE_CLEAR) |=> (out_valid && !busy))
    else $error("clear item did not give a beat");

  a_comp_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_mode == dcos_pkg::MODE_COMP) |=> (busy && !out_valid && state_r == S_ROW_RD))
    else $error("compute item did not start row walk");

  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE))
    else $error("busy out of step with state");
`endif

endmodule

// ===== rtl/dcos_dpath.sv =====
module dcos_dpath #(
  parameter int MAX_TASKS = dcos_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dcos_pkg::cmd_t               cmd,
  output dcos_pkg::stat_t              stat,
  input  logic                         cfg_we,
  input  logic [dcos_pkg::TASK_W-1:0]  cfg_wdata,
  input  logic [dcos_pkg::TASK_W-1:0]  in_from_task,
  input  logic [dcos_pkg::TASK_W-1:0]  in_to_task,
  output logic                         out_status,
  output logic [dcos_pkg::PAIR_W-1:0]  out_pair_count,
  output logic [dcos_pkg::STR_W-1:0]   out_order_strength
);

  localparam int IW      = $clog2(MAX_TASKS);
  localparam int NW      = $clog2(MAX_TASKS + 1);
  localparam int XW      = (NW > dcos_pkg::TASK_W) ? NW : dcos_pkg::TASK_W;
  localparam int MAXPAIR = MAX_TASKS * (MAX_TASKS - 1) / 2;
  localparam int CW      = $clog2(MAXPAIR + 1);
  localparam int QW      = dcos_pkg::QW;
  localparam int SW      = dcos_pkg::SW;

  // configuration
  logic [dcos_pkg::TASK_W-1:0] tc_r;
  logic [XW-1:0]               tc_x, max_x, n_eff_x, from_x, to_x;
  logic [NW-1:0]               n_eff;

  // matrix store
  logic [MAX_TASKS-1:0] valid_r;
  logic [IW-1:0]        raddr, rd_addr_r, waddr;
  logic [MAX_TASKS-1:0] rdata, rd_row, wdata;
  logic                 we;

  // edge and closure walk
  logic [IW-1:0]        ef_r, et_r;
  logic [NW-1:0]        n_r;
  logic [IW-1:0]        i_r, jd_r;
  logic [MAX_TASKS-1:0] row_r, n_mask, gt_mask;
  logic                 hit;
  logic [CW-1:0]        cnt_r;

  // divider
  logic [2*NW-1:0] prod;
  logic [CW-1:0]   den_r, rem_r, rem_nxt;
  logic [CW:0]     trial;
  logic            ge;
  logic [QW-1:0]   q_r, q_nxt;
  logic [SW-1:0]   step_r;

  // result
  logic                        status_r;
  logic [dcos_pkg::PAIR_W-1:0] pairs_r;
  logic [dcos_pkg::STR_W-1:0]  str_r;

  assign tc_x    = XW'(tc_r);
  assign max_x   = XW'(MAX_TASKS);
  assign n_eff_x = (tc_x < XW'(2)) ? XW'(2) : ((tc_x > max_x) ? max_x : tc_x);
  assign n_eff   = NW'(n_eff_x);
  assign from_x  = XW'(in_from_task);
  assign to_x    = XW'(in_to_task);

  assign stat.edge_ok   = (from_x != '0) && (from_x < to_x) && (to_x <= n_eff_x);
  assign stat.scan_last = (jd_r == IW'(n_r - NW'(1)));
  assign stat.row_last  = (i_r == IW'(n_r - NW'(2)));
  assign stat.div_last  = (step_r == SW'(QW - 1));

  always_comb begin
    raddr = '0;
    if (cmd.edge_rd) begin
      raddr = IW'(from_x - XW'(1));
    end else if (cmd.row_rd) begin
      raddr = i_r;
    end else if (cmd.row_ld) begin
      raddr = i_r + IW'(1);
    end else if (cmd.scan) begin
      raddr = jd_r + IW'(1);
    end
  end

  // a row never written since reset or clear reads as zeros
  assign rd_row = valid_r[rd_addr_r] ? rdata : '0;

  assign we    = cmd.edge_wr | cmd.row_wr;
  assign waddr = cmd.edge_wr ? ef_r : i_r;
  assign wdata = cmd.edge_wr ? (rd_row | (MAX_TASKS'(1) << et_r)) : row_r;

  dcos_ram #(
    .WIDTH (MAX_TASKS),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_mask  = (MAX_TASKS'(1) << n_r) - MAX_TASKS'(1);
  assign gt_mask = ~((MAX_TASKS'(2) << jd_r) - MAX_TASKS'(1));
  assign hit     = row_r[jd_r];

  assign prod  = (2*NW)'(n_r) * (2*NW)'(n_r - NW'(1));
  assign trial = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge    = (trial >= {1'b0, den_r});
  assign rem_nxt = ge ? CW'(trial - {1'b0, den_r}) : CW'(trial);
  assign q_nxt   = {q_r[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r    <= dcos_pkg::TASK_COUNT_RST;
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        tc_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        valid_r <= '0;
      end else if (we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= raddr;
    if (cmd.edge_rd) begin
      ef_r <= IW'(from_x - XW'(1));
      et_r <= IW'(to_x - XW'(1));
    end
    if (cmd.comp_start) begin
      n_r   <= n_eff;
      i_r   <= '0;
      cnt_r <= '0;
    end
    if (cmd.row_ld) begin
      row_r <= rd_row;
      jd_r  <= i_r + IW'(1);
    end
    if (cmd.scan) begin
      // pull successors of j beyond j and below n into row i
      if (hit) begin
        row_r <= row_r | (rd_row & gt_mask & n_mask);
      end
      cnt_r <= cnt_r + CW'(hit);
      jd_r  <= jd_r + IW'(1);
    end
    if (cmd.row_wr) begin
      i_r <= i_r + IW'(1);
    end
    if (cmd.den) begin
      den_r  <= CW'(prod >> 1);
      rem_r  <= cnt_r;
      step_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      step_r <= step_r + SW'(1);
    end
    case (cmd.res_sel)
      dcos_pkg::RES_OK: begin
        status_r <= 1'b0;
        pairs_r  <= '0;
        str_r    <= '0;
      end
      dcos_pkg::RES_BAD: begin
        status_r <= 1'b1;
        pairs_r  <= '0;
        str_r    <= '0;
      end
      dcos_pkg::RES_COMP: begin
        status_r <= 1'b0;
        pairs_r  <= dcos_pkg::PAIR_W'(cnt_r);
        str_r    <= dcos_pkg::STR_W'(q_nxt);
      end
      default: begin
        status_r <= status_r;
      end
    endcase
  end

  assign out_status         = status_r;
  assign out_pair_count     = pairs_r;
  assign out_order_strength = str_r;

endmodule

// ===== rtl/dag_closure_order_strength_top.sv =====
// Precedence matrix of a task graph with closure and order strength.
// Input: an item is taken when start is high and busy is low. in_mode picks
// add edge (in_from_task -> in_to_task), compute closure, or clear matrix.
// Output: exactly one result beat per item, out_valid high for one cycle
// with out_status, out_pair_count and out_order_strength (Q1.16). The
// receiver cannot stall; the beat is taken in the cycle it is shown.
// Config: cfg_we writes cfg_wdata into task_count; write only while idle.
// Flow: rejected edge, clear and unused mode give the beat in the cycle
// after accept. A good edge does a read-modify-write of one matrix row,
// and the beat follows the write cycle. Compute walks rows i = 0..n-2,
// reading every row j > i through the one-read-port matrix RAM, one row
// per cycle, then does one denominator step and a restoring divide that
// yields 17 quotient bits; the beat comes in the cycle after the last
// divide step.
// Reset: task_count returns to 64 and every row's valid bit is cleared, so
// the matrix reads as zeros at once; no sweep of the RAM is needed.
module dag_closure_order_strength_top #(
  parameter int MAX_TASKS = dcos_pkg::MAX_TASKS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dcos_pkg::MODE_W-1:0]  in_mode,
  input  logic [dcos_pkg::TASK_W-1:0]  in_from_task,
  input  logic [dcos_pkg::TASK_W-1:0]  in_to_task,
  output logic                         out_valid,
  output logic                         out_status,
  output logic [dcos_pkg::PAIR_W-1:0]  out_pair_count,
  output logic [dcos_pkg::STR_W-1:0]   out_order_strength,
  input  logic                         cfg_we,
  input  logic [dcos_pkg::TASK_W-1:0]  cfg_wdata
);

  dcos_pkg::cmd_t  cmd;
  dcos_pkg::stat_t stat;

  dcos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_mode   (in_mode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dcos_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_from_task       (in_from_task),
    .in_to_task         (in_to_task),
    .out_status         (out_status),
    .out_pair_count     (out_pair_count),
    .out_order_strength (out_order_strength)
  );

endmodule

// ===== dv/dag_closure_order_strength_checker.sv =====
`timescale 1ns / 1ps

module dag_closure_order_strength_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [dcos_pkg::MODE_W-1:0]  in_mode,
  input  logic [dcos_pkg::TASK_W-1:0]  in_from_task,
  input  logic [dcos_pkg::TASK_W-1:0]  in_to_task,
  input  logic                         out_valid,
  input  logic                         out_status,
  input  logic [dcos_pkg::PAIR_W-1:0]  out_pair_count,
  input  logic [dcos_pkg::STR_W-1:0]   out_order_strength,
  input  logic                         cfg_we,
  input  logic [dcos_pkg::TASK_W-1:0]  cfg_wdata,
  output int                           fail_count,
  output int                           outstanding
);

  localparam int TASKS = dcos_pkg::MAX_TASKS_DEF;

  typedef struct packed {
    logic                        status;
    logic [dcos_pkg::PAIR_W-1:0] pair_count;
    logic [dcos_pkg::STR_W-1:0]  strength;
  } order_result_t;

  // row i holds the successors of task i+1, bit k for task k+1
  logic [TASKS-1:0]            prec_rows [TASKS];
  logic [dcos_pkg::TASK_W-1:0] task_count;
  order_result_t               awaited_results [$];

  function automatic int tasks_in_use();
    int n;
    n = task_count;
    if (n < 2) n = 2;
    if (n > TASKS) n = TASKS;
    return n;
  endfunction

  function automatic order_result_t order_item_result(
    input logic [dcos_pkg::MODE_W-1:0] mode,
    input logic [dcos_pkg::TASK_W-1:0] from_task,
    input logic [dcos_pkg::TASK_W-1:0] to_task
  );
    order_result_t     res;
    int                n;
    longint unsigned   pairs;
    longint unsigned   denom;
    n   = tasks_in_use();
    res = '0;
    case (mode)
      dcos_pkg::MODE_ADD: begin
        if (from_task >= 1 && from_task < to_task && to_task <= n)
          prec_rows[from_task-1][to_task-1] = 1'b1;
        else
          res.status = 1'b1;
      end
      dcos_pkg::MODE_COMP: begin
        // ordered closure: rows grow in place, so later j see earlier merges
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++)
            if (prec_rows[i][j])
              for (int k = j + 1; k < n; k++)
                if (prec_rows[j][k]) prec_rows[i][k] = 1'b1;
        pairs = 0;
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++)
            if (prec_rows[i][j]) pairs++;
        denom          = longint'(n) * longint'(n - 1) / 2;
        res.pair_count = pairs[dcos_pkg::PAIR_W-1:0];
        res.strength   = dcos_pkg::STR_W'((pairs << 16) / denom);
      end
      dcos_pkg::MODE_CLEAR: begin
        for (int i = 0; i < TASKS; i++) prec_rows[i] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    order_result_t exp_res;
    if (!rst_n) begin
      for (int i = 0; i < TASKS; i++) prec_rows[i] = '0;
      task_count = dcos_pkg::TASK_COUNT_RST;
      awaited_results.delete();
    end else begin
      // check the result beat before queueing the item taken at this edge
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none awaited: status %0d pairs %0d strength %0d",
                   $time, out_status, out_pair_count, out_order_strength);
          fail_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_status !== exp_res.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp_res.status, out_status);
            fail_count++;
          end
          if (out_pair_count !== exp_res.pair_count) begin
            $display("%0t: pair_count expected %0d got %0d",
                     $time, exp_res.pair_count, out_pair_count);
            fail_count++;
          end
          if (out_order_strength !== exp_res.strength) begin
            $display("%0t: order_strength expected %0d got %0d",
                     $time, exp_res.strength, out_order_strength);
            fail_count++;
          end
        end
      end
      if (cfg_we) task_count = cfg_wdata;
      if (start && !busy)
        awaited_results.push_back(order_item_result(in_mode, in_from_task, in_to_task));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== dv/dag_closure_order_strength_top_test.sv =====
`timescale 1ns / 1ps

module dag_closure_order_strength_top_test;

  localparam logic [dcos_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASE_ITEMS = 70;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [dcos_pkg::MODE_W-1:0] in_mode;
  logic [dcos_pkg::TASK_W-1:0] in_from_task;
  logic [dcos_pkg::TASK_W-1:0] in_to_task;
  logic                        out_valid;
  logic                        out_status;
  logic [dcos_pkg::PAIR_W-1:0] out_pair_count;
  logic [dcos_pkg::STR_W-1:0]  out_order_strength;
  logic                        cfg_we;
  logic [dcos_pkg::TASK_W-1:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int active_tasks = 64;
  int items_sent = 0;

  dag_closure_order_strength_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_from_task       (in_from_task),
    .in_to_task         (in_to_task),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_pair_count     (out_pair_count),
    .out_order_strength (out_order_strength),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  dag_closure_order_strength_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_from_task       (in_from_task),
    .in_to_task         (in_to_task),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_pair_count     (out_pair_count),
    .out_order_strength (out_order_strength),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .outstanding        (outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // count cycles with no beat on either side
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_item(input logic [dcos_pkg::MODE_W-1:0] mode,
                           input logic [dcos_pkg::TASK_W-1:0] from_task,
                           input logic [dcos_pkg::TASK_W-1:0] to_task);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_mode      <= mode;
    in_from_task <= from_task;
    in_to_task   <= to_task;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_task_count(input logic [dcos_pkg::TASK_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    active_tasks = (value < 2) ? 2 :
                   (value > dcos_pkg::MAX_TASKS_DEF) ? dcos_pkg::MAX_TASKS_DEF : value;
  endtask

  // clear now and then, load edges, then close and measure when with_compute is set
  task automatic run_graph(input int bad_pct, input bit with_compute);
    int n_edges;
    int from_task;
    int to_task;
    if ($urandom_range(99) < 30)
      send_item(dcos_pkg::MODE_CLEAR, dcos_pkg::TASK_W'($urandom_range(127)),
                dcos_pkg::TASK_W'($urandom_range(127)));
    n_edges = $urandom_range(14, 1);
    repeat (n_edges) begin
      if ($urandom_range(99) < bad_pct) begin
        send_item(dcos_pkg::MODE_ADD, dcos_pkg::TASK_W'($urandom_range(127)),
                  dcos_pkg::TASK_W'($urandom_range(127)));
      end else begin
        from_task = $urandom_range(active_tasks - 1, 1);
        to_task   = $urandom_range(1) ? from_task + 1 : $urandom_range(active_tasks, from_task + 1);
        send_item(dcos_pkg::MODE_ADD, dcos_pkg::TASK_W'(from_task), dcos_pkg::TASK_W'(to_task));
      end
    end
    if ($urandom_range(99) < 4) wait_drained();
    if (with_compute)
      send_item(dcos_pkg::MODE_COMP, dcos_pkg::TASK_W'($urandom_range(127)),
                dcos_pkg::TASK_W'($urandom_range(127)));
  endtask

  initial begin
    int phase_cfg [9];
    int phase_idle [4];
    int pick;
    phase_cfg    = '{2, 127, 10, 0, 33, 64, 5, 1, 20};
    phase_idle   = '{0, 75, 0, 34};
    rst_n        = 1'b0;
    start        = 1'b0;
    in_mode      = dcos_pkg::MODE_ADD;
    in_from_task = '0;
    in_to_task   = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed, with the reset task count of 64
    send_item(dcos_pkg::MODE_COMP, 7'd0, 7'd0);
    send_item(dcos_pkg::MODE_ADD, 7'd1, 7'd64);
    send_item(dcos_pkg::MODE_ADD, 7'd63, 7'd64);
    send_item(dcos_pkg::MODE_ADD, 7'd1, 7'd2);
    send_item(dcos_pkg::MODE_ADD, 7'd2, 7'd3);
    send_item(dcos_pkg::MODE_ADD, 7'd3, 7'd63);
    send_item(dcos_pkg::MODE_ADD, 7'd0, 7'd5);
    send_item(dcos_pkg::MODE_ADD, 7'd5, 7'd5);
    send_item(dcos_pkg::MODE_ADD, 7'd9, 7'd4);
    send_item(dcos_pkg::MODE_ADD, 7'd10, 7'd65);
    send_item(dcos_pkg::MODE_ADD, 7'd127, 7'd127);
    send_item(dcos_pkg::MODE_ADD, 7'd64, 7'd64);
    send_item(MODE_UNUSED, 7'd127, 7'd127);
    send_item(MODE_UNUSED, 7'd0, 7'd0);
    send_item(dcos_pkg::MODE_COMP, 7'd127, 7'd127);
    send_item(dcos_pkg::MODE_COMP, 7'd0, 7'd0);
    send_item(dcos_pkg::MODE_CLEAR, 7'd0, 7'd0);
    send_item(dcos_pkg::MODE_COMP, 7'd0, 7'd0);

    // keep the matrix across phases so stale rows beyond n get exercised
    for (int p = 0; p < 9; p++) begin
      write_task_count(dcos_pkg::TASK_W'(phase_cfg[p]));
      idle_pct = phase_idle[p % 4];
      pick = items_sent + PHASE_ITEMS;
      while (items_sent < pick) begin
        case ($urandom_range(9))
          0, 1:    send_item(dcos_pkg::MODE_W'($urandom_range(3)),
                             dcos_pkg::TASK_W'($urandom_range(127)),
                             dcos_pkg::TASK_W'($urandom_range(127)));
          2:       run_graph(40, $urandom_range(1));
          default: run_graph(0, 1'b1);
        endcase
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
